// File: sv/object_x_insertion_sort_defines.svh
// ----------------------------------------------------------------------------
// Object x insertion sort: assertion macros
// Shared property macros for the checker. Every macro samples on clk and is
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef OBJECT_X_INSERTION_SORT_DEFINES_SVH
`define OBJECT_X_INSERTION_SORT_DEFINES_SVH

// Whenever ante holds in a cycle, cons must hold in that same cycle.
`define OXIS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen at a clock edge.
`define OXIS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: sv/oxis_pkg.sv
// ----------------------------------------------------------------------------
// Object x insertion sort: package
// Fixed field widths and the address constants of the object record grid.
// ----------------------------------------------------------------------------
package oxis_pkg;

  localparam int WORD_W = 16;
  localparam int CNT_W  = 4;

  // Object records lie at OBJ_BASE plus 256 times the object index.
  localparam logic [WORD_W-1:0] OBJ_BASE  = 16'h34eb;
  localparam int                OBJ_SHIFT = 8;

  // Link word written for an object that moves to position p is LINK_BASE + 2p.
  localparam logic [WORD_W-1:0] LINK_BASE = 16'h34d3;

  // The record counter stops at its all-ones value.
  localparam logic [CNT_W-1:0] CNT_MAX = 4'hf;

endpackage

// File: sv/oxis_ptr_check.sv
// ----------------------------------------------------------------------------
// Object x insertion sort: pointer check
// Maps an object pointer to its object index and flags pointers that are
// off the record grid or beyond the last object.
// ----------------------------------------------------------------------------
module oxis_ptr_check #(
  parameter int ENTRIES = 11
) (
  input  logic [oxis_pkg::WORD_W-1:0] ptr,
  output logic                        valid,
  output logic [$clog2(ENTRIES)-1:0]  idx
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [oxis_pkg::WORD_W-1:0] offset;

  assign offset = ptr - oxis_pkg::OBJ_BASE;

  // The offset must be a whole multiple of the stride and name an existing object.
  assign valid = (ptr >= oxis_pkg::OBJ_BASE) &&
                 (offset[oxis_pkg::OBJ_SHIFT-1:0] == '0) &&
                 (offset[oxis_pkg::WORD_W-1:oxis_pkg::OBJ_SHIFT] <=
                  (oxis_pkg::WORD_W - oxis_pkg::OBJ_SHIFT)'(ENTRIES - 1));

  assign idx = offset[oxis_pkg::OBJ_SHIFT +: IDX_W];

endmodule

// File: sv/object_x_insertion_sort.sv
// ----------------------------------------------------------------------------
// Object x insertion sort: top level
// Loads a set of object records, insertion-sorts them by x coordinate in a
// small record memory and emits the sorted pointers with their link words.
// ----------------------------------------------------------------------------
// Loading accepts one record per cycle; busy stays low until the final record.
// A rejected set gives its single error word in the cycle after the final record.
// An accepted set keeps busy high for the sort and emit, both paced by the
// single read port of the record memory.
// Reset (rst, synchronous) empties the set; the receiver cannot stall.
module object_x_insertion_sort #(
  parameter int ENTRIES = 11
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic        [oxis_pkg::WORD_W-1:0] object_pointer,
  input  logic signed [oxis_pkg::WORD_W-1:0] x_coord,
  input  logic        [oxis_pkg::WORD_W-1:0] link_in,
  input  logic                               last,
  output logic                               strobe,
  output logic        [oxis_pkg::WORD_W-1:0] sorted_pointer,
  output logic        [oxis_pkg::WORD_W-1:0] link_out,
  output logic                               error,
  output logic                               last_out
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int W     = oxis_pkg::WORD_W;
  // A record memory word holds the object index above the x coordinate.
  localparam int ORD_W = IDX_W + W;

  localparam logic [IDX_W-1:0]          LAST_POS  = IDX_W'(ENTRIES - 1);
  localparam logic [oxis_pkg::CNT_W-1:0] FULL_CNT = oxis_pkg::CNT_W'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CUR,
    S_CMP,
    S_PLACE,
    S_EMIT,
    S_DRAIN
  } state_t;

  state_t state;

  // Record memory by sorted position, link memory by object index.
  logic [ORD_W-1:0] order_mem [ENTRIES];
  logic [W-1:0]     link_mem  [ENTRIES];

  logic [ORD_W-1:0] ord_q;
  logic [W-1:0]     link_q;

  logic [IDX_W-1:0] rd_addr;
  logic             ord_we;
  logic [IDX_W-1:0] ord_waddr;
  logic [ORD_W-1:0] ord_wdata;

  // Set collection state.
  logic [ENTRIES-1:0]          seen_mask;
  logic [oxis_pkg::CNT_W-1:0]  load_count;
  logic                        bad_flag;

  // Sort state: i is the position being inserted, at is its current hole,
  // cur holds the record that is being inserted.
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] at;
  logic [ORD_W-1:0] cur;
  logic             cur_moved;
  logic [ENTRIES-1:0] moved;

  // Emit pipeline.
  logic [IDX_W-1:0] k;
  logic             e1_valid;
  logic [IDX_W-1:0] e1_pos;
  logic             e2_valid;
  logic [IDX_W-1:0] e2_pos;
  logic [IDX_W-1:0] e2_idx;

  // Load decode.
  logic                        p_ok;
  logic [IDX_W-1:0]            p_idx;
  logic                        accept;
  logic                        load_ok;
  logic [oxis_pkg::CNT_W-1:0]  count_next;
  logic                        set_ok;

  // Compare.
  logic [W-1:0] diff;
  logic         move;

  oxis_ptr_check #(
    .ENTRIES (ENTRIES)
  ) u_ptr_check (
    .ptr   (object_pointer),
    .valid (p_ok),
    .idx   (p_idx)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    load_ok = (load_count < FULL_CNT) && p_ok && !(seen_mask[p_idx]);
    if (load_count == oxis_pkg::CNT_MAX) begin
      count_next = load_count;
    end else begin
      count_next = load_count + 1'b1;
    end
    set_ok = !bad_flag && load_ok && (count_next == FULL_CNT);
  end

  // The record ahead of the hole moves down while its x minus the inserted x,
  // taken modulo 2^16, is nonzero and has its top bit clear.
  assign diff = ord_q[W-1:0] - cur[W-1:0];
  assign move = (diff != '0) && !diff[W-1];

  // Read address: the record to insert, the record ahead of the hole (fetched
  // one step early so that a shift does not wait on a read), or the emit position.
  always_comb begin
    case (state)
      S_FETCH: rd_addr = i;
      S_CUR:   rd_addr = i - 1'b1;
      S_CMP:   rd_addr = at - IDX_W'(2);
      S_PLACE: rd_addr = i + 1'b1;
      S_EMIT:  rd_addr = k;
      default: rd_addr = '0;
    endcase
  end

  // Write port: loads, shifts of a record into the hole, and final placement.
  // During the sort a write never meets the read of the same entry in one cycle.
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = at;
    ord_wdata = cur;
    case (state)
      S_IDLE: begin
        ord_we    = accept && load_ok;
        ord_waddr = load_count[IDX_W-1:0];
        ord_wdata = {p_idx, x_coord};
      end
      S_CMP: begin
        ord_we    = move;
        ord_wdata = ord_q;
      end
      S_PLACE: begin
        ord_we = 1'b1;
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= order_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && load_ok) begin
      link_mem[p_idx] <= link_in;
    end
    link_q <= link_mem[ord_q[ORD_W-1:W]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seen_mask  <= '0;
      load_count <= '0;
      bad_flag   <= 1'b0;
      moved      <= '0;
      cur_moved  <= 1'b0;
      e1_valid   <= 1'b0;
      e2_valid   <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      e1_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (load_ok) begin
              seen_mask[p_idx] <= 1'b1;
            end else begin
              bad_flag <= 1'b1;
            end
            load_count <= count_next;
            if (last) begin
              // The set ends here whether or not it is accepted.
              seen_mask  <= '0;
              load_count <= '0;
              bad_flag   <= 1'b0;
              if (set_ok) begin
                i     <= IDX_W'(1);
                moved <= '0;
                state <= S_FETCH;
              end else begin
                strobe         <= 1'b1;
                sorted_pointer <= '0;
                link_out       <= '0;
                error          <= 1'b1;
                last_out       <= 1'b1;
              end
            end
          end
        end
        S_FETCH: begin
          state <= S_CUR;
        end
        S_CUR: begin
          cur       <= ord_q;
          at        <= i;
          cur_moved <= 1'b0;
          state     <= S_CMP;
        end
        S_CMP: begin
          if (move) begin
            moved[ord_q[ORD_W-1:W]] <= 1'b1;
            cur_moved               <= 1'b1;
            at                      <= at - 1'b1;
            if (at == IDX_W'(1)) begin
              state <= S_PLACE;
            end
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (cur_moved) begin
            moved[cur[ORD_W-1:W]] <= 1'b1;
          end
          if (i == LAST_POS) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            i     <= i + 1'b1;
            state <= S_CUR;
          end
        end
        S_EMIT: begin
          e1_valid <= 1'b1;
          e1_pos   <= k;
          if (k == LAST_POS) begin
            state <= S_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          if (e2_valid && (e2_pos == LAST_POS)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Emit pipeline: record read, then link read, then the output word.
      e2_valid <= e1_valid;
      e2_pos   <= e1_pos;
      e2_idx   <= ord_q[ORD_W-1:W];
      if (e2_valid) begin
        strobe         <= 1'b1;
        sorted_pointer <= W'(oxis_pkg::OBJ_BASE + (W'(e2_idx) << oxis_pkg::OBJ_SHIFT));
        // An object that ever moved carries the link of its final position;
        // an object that never moved keeps the link it was loaded with.
        if (moved[e2_idx]) begin
          link_out <= W'(oxis_pkg::LINK_BASE + (W'(e2_pos) << 1));
        end else begin
          link_out <= link_q;
        end
        error    <= 1'b0;
        last_out <= (e2_pos == LAST_POS);
      end
    end
  end

endmodule

// File: sv/oxis_checker.sv
// ----------------------------------------------------------------------------
// Object x insertion sort: port checker
// Watches the top level's ports and checks the ordering of busy, error words
// and the final word of a sorted run.
// ----------------------------------------------------------------------------
`include "object_x_insertion_sort_defines.svh"

module oxis_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        last,
  input logic                        strobe,
  input logic [oxis_pkg::WORD_W-1:0] sorted_pointer,
  input logic [oxis_pkg::WORD_W-1:0] link_out,
  input logic                        error,
  input logic                        last_out
);

  `OXIS_ASSERT_NEVER(a_err_word_clean, strobe && error && (!last_out || (sorted_pointer != '0) || (link_out != '0)), "error word must be a zero final word")

  `OXIS_ASSERT_IMP(a_err_after_final, strobe && error, $past(start && !busy && last), "error word without a final record one cycle before")

  `OXIS_ASSERT_IMP(a_run_busy, strobe && !error && !last_out, busy, "sorted word shown while idle")

  `OXIS_ASSERT_IMP(a_ptr_grid, strobe && !error, sorted_pointer[7:0] == oxis_pkg::OBJ_BASE[7:0], "sorted pointer off the record grid")

  `OXIS_ASSERT_IMP(a_busy_end, $fell(busy), strobe && last_out && !error, "busy dropped without the final sorted word")

endmodule

bind object_x_insertion_sort oxis_checker u_oxis_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .last           (last),
  .strobe         (strobe),
  .sorted_pointer (sorted_pointer),
  .link_out       (link_out),
  .error          (error),
  .last_out       (last_out)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Object x insertion sort: testbench
// Sends sets of object records to the sorter, predicts the sorted words
// (or the single error word of a rejected set) and checks every strobed word.
// ----------------------------------------------------------------------------
module tb_top;

  // Set size of the block under test; a set is accepted only at this count.
  localparam int N         = 11;
  // Number of input words to send before the run winds down.
  localparam int ITEMS     = 170;
  // The longest quiet stretch of a correct run is a full sort ahead of the
  // first sorted word behind a random sender gap, so this leaves a wide margin.
  localparam int STALL_MAX = 1000;
  // Cycles to watch for stray words once nothing more is predicted.
  localparam int DRAIN     = 100;

  typedef logic [oxis_pkg::WORD_W-1:0] word_t;

  typedef struct packed {
    word_t ptr;
    word_t link;
    logic  err;
    logic  fin;
  } sort_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the record set, the sort that follows the
  // final record, and the queue of sorted words that must still come out.
  // --------------------------------------------------------------------------
  class sort_scoreboard;
    word_t                      pos_ptr [N];   // pointers in load order, then sorted order
    word_t                      obj_x   [N];   // x coordinate by object index
    word_t                      obj_link[N];   // link word by object index
    logic [N-1:0]               seen;
    logic [oxis_pkg::CNT_W-1:0] count;
    bit                         bad;
    sort_word_t                 due_q[$];
    int                         errors;

    function new();
      foreach (pos_ptr[i]) begin
        pos_ptr[i]  = '0;
        obj_x[i]    = '0;
        obj_link[i] = '0;
      end
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      seen  = '0;
      count = '0;
      bad   = 1'b0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Maps a pointer to its object index; only base + 256*k with k < N is
    // on the grid. Off the grid the index reads as zero.
    function bit grid_index(word_t p, output int idx);
      int d;
      d   = int'(p) - int'(oxis_pkg::OBJ_BASE);
      idx = 0;
      if (d < 0 || d > (N - 1) * (1 << oxis_pkg::OBJ_SHIFT) ||
          (d % (1 << oxis_pkg::OBJ_SHIFT)) != 0)
        return 1'b0;
      idx = d >> oxis_pkg::OBJ_SHIFT;
      return 1'b1;
    endfunction

    // Insertion sort by x. An entry steps down while previous minus current,
    // taken modulo 2^16, is nonzero with its top bit clear. Each step gives
    // both objects the link word of their new position.
    function void sort_set();
      int    at, cur, prev;
      word_t diff, tmp;
      for (int i = 1; i < N; i++) begin
        at = i;
        void'(grid_index(pos_ptr[at], cur));
        while (at > 0) begin
          void'(grid_index(pos_ptr[at-1], prev));
          diff = obj_x[prev] - obj_x[cur];
          if (diff == '0 || diff[oxis_pkg::WORD_W-1])
            break;
          tmp             = pos_ptr[at];
          pos_ptr[at]     = pos_ptr[at-1];
          pos_ptr[at-1]   = tmp;
          obj_link[prev]  = oxis_pkg::LINK_BASE + word_t'(2 * at);
          obj_link[cur]   = oxis_pkg::LINK_BASE + word_t'(2 * (at - 1));
          at--;
        end
      end
    endfunction

    // Called for every accepted input word.
    function void note_word(word_t p, word_t x, word_t link, logic fin);
      int         idx;
      sort_word_t w;
      if (count >= N) begin
        bad = 1'b1;
      end else if (!grid_index(p, idx) || seen[idx]) begin
        bad = 1'b1;
      end else begin
        seen[idx]     = 1'b1;
        pos_ptr[count] = p;
        obj_x[idx]    = x;
        obj_link[idx] = link;
      end
      if (count != oxis_pkg::CNT_MAX)
        count++;
      if (!fin)
        return;
      if (bad || count != N) begin
        w.ptr  = '0;
        w.link = '0;
        w.err  = 1'b1;
        w.fin  = 1'b1;
        due_q.push_back(w);
        clear_set();
        return;
      end
      sort_set();
      for (int k = 0; k < N; k++) begin
        void'(grid_index(pos_ptr[k], idx));
        w.ptr  = pos_ptr[k];
        w.link = obj_link[idx];
        w.err  = 1'b0;
        w.fin  = (k == N - 1);
        due_q.push_back(w);
      end
      clear_set();
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    // Called for every strobed result word.
    task check_word(word_t ptr, word_t link, logic err, logic fin);
      sort_word_t want;
      if (due_q.size() == 0) begin
        report($sformatf("word with nothing predicted: ptr %h link %h error %b last %b",
                         ptr, link, err, fin));
        return;
      end
      want = due_q.pop_front();
      if (ptr !== want.ptr)
        report($sformatf("sorted_pointer %h, predicted %h", ptr, want.ptr));
      if (link !== want.link)
        report($sformatf("link_out %h, predicted %h (ptr %h)", link, want.link, want.ptr));
      if (err !== want.err)
        report($sformatf("error %b, predicted %b", err, want.err));
      if (fin !== want.fin)
        report($sformatf("last_out %b, predicted %b", fin, want.fin));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                               clk            = 1'b0;
  logic                               rst            = 1'b1;
  logic                               start          = 1'b0;
  logic                               busy;
  word_t                              object_pointer = '0;
  logic signed [oxis_pkg::WORD_W-1:0] x_coord        = '0;
  word_t                              link_in        = '0;
  logic                               last           = 1'b0;
  logic                               strobe;
  word_t                              sorted_pointer;
  word_t                              link_out;
  logic                               error;
  logic                               last_out;

  always #2 clk = ~clk;

  object_x_insertion_sort #(
    .ENTRIES(N)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .object_pointer(object_pointer),
    .x_coord       (x_coord),
    .link_in       (link_in),
    .last          (last),
    .strobe        (strobe),
    .sorted_pointer(sorted_pointer),
    .link_out      (link_out),
    .error         (error),
    .last_out      (last_out)
  );

  sort_scoreboard board = new();

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Everything is sampled at the rising edge, where the
  // block's outputs and our own nonblocking drives still hold their values
  // from the cycle that the edge closes.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (start === 1'b1 && busy === 1'b0)
        board.note_word(object_pointer, x_coord, link_in, last);
      if (strobe !== 1'b0)
        board.check_word(sorted_pointer, link_out, error, last_out);
      if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_MAX) begin
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. A set is built in the three queues below and then sent word by
  // word, with last raised on its final word.
  // --------------------------------------------------------------------------
  word_t set_ptr[$];
  word_t set_x[$];
  word_t set_link[$];
  int    items_sent = 0;
  bit    gaps_on    = 1'b0;   // sender inserts random idle bursts when set

  // Holds the word on the ports until an edge sees busy low.
  task automatic send_word(word_t p, word_t x, word_t link, logic fin);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start          <= 1'b1;
    object_pointer <= p;
    x_coord        <= x;
    link_in        <= link;
    last           <= fin;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic send_set();
    for (int i = 0; i < set_ptr.size(); i++)
      send_word(set_ptr[i], set_x[i], set_link[i], i == set_ptr.size() - 1);
    items_sent += set_ptr.size();
    set_ptr.delete();
    set_x.delete();
    set_link.delete();
  endtask

  task automatic add_rec(word_t p, word_t x, word_t link);
    set_ptr.push_back(p);
    set_x.push_back(x);
    set_link.push_back(link);
  endtask

  // Stops sending until every predicted word has come out.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic word_t grid_ptr(int k);
    return oxis_pkg::OBJ_BASE + word_t'(k << oxis_pkg::OBJ_SHIFT);
  endfunction

  // X values: fully random, a few corner values (many ties and diffs that
  // wrap past the sign bit), or a narrow window so that ties are common.
  function automatic word_t pick_x(int mode);
    word_t corner[4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    case (mode)
      0:       return word_t'($urandom);
      1:       return corner[$urandom_range(0, 3)];
      default: return word_t'($urandom_range(0, 7)) + word_t'(16'h7ffc);
    endcase
  endfunction

  // A complete, well-formed set in random order.
  task automatic build_valid_set();
    int perm[N];
    int j, t, mode;
    foreach (perm[i]) perm[i] = i;
    for (int i = N - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    mode = $urandom_range(0, 3);
    foreach (perm[i]) add_rec(grid_ptr(perm[i]), pick_x(mode == 3 ? 0 : mode),
                              word_t'($urandom));
  endtask

  // A set that must be rejected: too short, too long, one record spoiled,
  // or plain noise.
  task automatic build_broken_set();
    int kind, n, j;
    build_valid_set();
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        n = $urandom_range(1, N - 1);
        while (set_ptr.size() > n) begin
          void'(set_ptr.pop_back());
          void'(set_x.pop_back());
          void'(set_link.pop_back());
        end
      end
      1: begin
        n = $urandom_range(1, 6);
        repeat (n) add_rec(grid_ptr($urandom_range(0, N - 1)), pick_x(0), word_t'($urandom));
      end
      2: begin
        j = $urandom_range(0, N - 1);
        case ($urandom_range(0, 2))
          0:       set_ptr[j] = set_ptr[(j + 1) % N];   // repeated object
          1:       set_ptr[j] = set_ptr[j] + word_t'($urandom_range(1, 255));
          default: set_ptr[j] = word_t'($urandom);
        endcase
      end
      default: begin
        set_ptr.delete();
        set_x.delete();
        set_link.delete();
        n = $urandom_range(1, 17);
        repeat (n) add_rec(($urandom_range(0, 1) != 0) ? grid_ptr($urandom_range(0, N - 1))
                                                       : word_t'($urandom),
                           pick_x(0), word_t'($urandom));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  word_t directed_x[N] = '{16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
                           16'h4000, 16'hc000, 16'h8000, 16'h0000, 16'h7ffe};
  int    sets_done = 0;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: a full set loaded in descending object order with corner x
    // values, so ties, sign-bit wraparound and long moves all occur, and the
    // link words take both extremes.
    for (int i = 0; i < N; i++)
      add_rec(grid_ptr(N - 1 - i), directed_x[i], (i % 2 != 0) ? 16'hffff : 16'h0000);
    send_set();
    wait_for_drain();

    // Pointer below the grid, above it, one off the grid step, a repeated object,
    // a lone valid record (count short of a full set), and one step past the grid top.
    add_rec(16'h0000, 16'h0000, 16'h0000);
    send_set();
    add_rec(16'hffff, 16'hffff, 16'hffff);
    send_set();
    add_rec(oxis_pkg::OBJ_BASE + 16'h0001, 16'h1234, 16'h5678);
    send_set();
    add_rec(grid_ptr(0), 16'h0010, 16'h1111);
    add_rec(grid_ptr(0), 16'h0020, 16'h2222);
    send_set();
    add_rec(grid_ptr(N - 1), 16'h8000, 16'hffff);
    send_set();
    add_rec(grid_ptr(N), 16'h0000, 16'h0000);   // first step past the top of the grid
    send_set();
    wait_for_drain();

    // Random sets: mostly well-formed with random content, the rest broken.
    // Sender gaps come and go per set and stop for the final stretch.
    while (items_sent < ITEMS) begin
      gaps_on = (items_sent < ITEMS - 30) && ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) < 7)
        build_valid_set();
      else
        build_broken_set();
      send_set();
      sets_done++;
      if (sets_done % 5 == 0)
        wait_for_drain();
    end

    gaps_on = 1'b0;
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
